### design/base64_variant_codec_macros.svh
// assertion macros for the base64 variant codec
// used by base64_variant_codec.sv; expects clk and rst in scope
`ifndef BASE64_VARIANT_CODEC_MACROS_SVH
`define BASE64_VARIANT_CODEC_MACROS_SVH

// same-cycle implication, checked outside reset
`define B64VC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define B64VC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/b64vc_pkg.sv
// types, constants and lookup functions for the base64 variant codec
// no dependencies
`timescale 1ns / 1ps

package b64vc_pkg;

  // direction register codes
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // decode value codes outside the 6-bit alphabet
  localparam logic [7:0] PAD_VALUE = 8'd64;
  localparam logic [7:0] BAD_VALUE = 8'd255;

  // character codes
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
  localparam logic [7:0] CHAR_PLUS    = 8'h2b;
  localparam logic [7:0] CHAR_HASH    = 8'h23;
  localparam logic [7:0] CHAR_PAD     = 8'h3d;

  // output counts
  localparam logic [2:0] COUNT_NONE    = 3'd0;
  localparam logic [2:0] COUNT_ENCODED = 3'd4;
  localparam logic [2:0] COUNT_FULL    = 3'd3;

  // input register stage
  typedef struct packed {
    logic       dir;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [2:0] count;
  } s1_t;

  // code stage: encode holds {0, pad, index}, decode holds the char value
  typedef struct packed {
    logic       dir;
    logic       empty;
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic [7:0] c3;
  } s2_t;

  // result stage
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [2:0] count;
    logic       error;
  } res_t;

  // alphabet index (bit 6 marks padding) to character
  function automatic logic [7:0] enc_char(input logic [6:0] code);
    logic [7:0] idx;
    logic [7:0] ch;
    idx = {2'b00, code[5:0]};
    if (code[6]) begin
      ch = CHAR_PAD;
    end else if (idx < 8'd26) begin
      ch = 8'(CHAR_UPPER_A + idx);
    end else if (idx < 8'd52) begin
      ch = 8'(CHAR_LOWER_A + idx - 8'd26);
    end else if (idx < 8'd62) begin
      ch = 8'(CHAR_DIGIT_0 + idx - 8'd52);
    end else if (idx == 8'd62) begin
      ch = CHAR_PLUS;
    end else begin
      ch = CHAR_HASH;
    end
    return ch;
  endfunction

  // character to value: 0..63, padding, or bad
  function automatic logic [7:0] dec_value(input logic [7:0] c);
    logic [7:0] v;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      v = 8'(c - CHAR_UPPER_A);
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      v = 8'(c - CHAR_LOWER_A + 8'd26);
    end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      v = 8'(c - CHAR_DIGIT_0 + 8'd52);
    end else if (c == CHAR_PLUS) begin
      v = 8'd62;
    end else if (c == CHAR_HASH) begin
      v = 8'd63;
    end else if (c == CHAR_PAD) begin
      v = PAD_VALUE;
    end else begin
      v = BAD_VALUE;
    end
    return v;
  endfunction

endpackage

### design/base64_variant_codec.sv
// base64 group encoder/decoder with a '+' '#' alphabet, three register stages
// depends on b64vc_pkg and base64_variant_codec_macros.svh
`timescale 1ns / 1ps

`include "base64_variant_codec_macros.svh"

// Converts one base64 group per item: with direction 0 one to three bytes
// become four characters ('=' pads), with direction 1 four characters
// become three bytes and a byte count, and a character that is neither in
// the alphabet nor '=' sets out_error. The block takes one item every cycle
// while the output is not stalled. The item passes through three registers:
// an input register, a stage that turns bytes into 6-bit indices or
// characters into values, and the result register that maps indices to
// characters or packs values into bytes. Each stage advances when it is
// empty or the stage after it moves, so an output stall holds items in
// place and at most three items are in flight.
// Write direction only while no item is in flight.
module base64_variant_codec (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_b0,
  input  logic [7:0] in_b1,
  input  logic [7:0] in_b2,
  input  logic [7:0] in_b3,
  input  logic [2:0] in_count,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_b0,
  output logic [7:0] out_b1,
  output logic [7:0] out_b2,
  output logic [7:0] out_b3,
  output logic [2:0] out_count,
  output logic       out_error
);

  import b64vc_pkg::*;

  logic direction;
  s1_t  s1;
  logic s1_valid;
  s2_t  s2;
  s2_t  s2_next;
  logic s2_valid;
  res_t res;
  res_t res_next;
  logic res_valid;
  logic ready2;
  logic ready3;

  // direction register
  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_ENCODE;
    end else if (cfg_we) begin
      direction <= cfg_wdata;
    end
  end

  // stage enables, each stage moves when empty or drained
  assign ready3   = !res_valid || out_ready;
  assign ready2   = !s2_valid || ready3;
  assign in_ready = !s1_valid || ready2;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1.dir   <= direction;
      s1.b0    <= in_b0;
      s1.b1    <= in_b1;
      s1.b2    <= in_b2;
      s1.b3    <= in_b3;
      s1.count <= in_count;
    end
  end

  // bytes to padded indices, or characters to values
  always_comb begin
    logic [1:0] len;
    logic [7:0] m0;
    logic [7:0] m1;
    logic [7:0] m2;
    len = (s1.count > 3'd3) ? 2'd3 : s1.count[1:0];
    m0  = (len >= 2'd1) ? s1.b0 : 8'd0;
    m1  = (len >= 2'd2) ? s1.b1 : 8'd0;
    m2  = (len == 2'd3) ? s1.b2 : 8'd0;
    s2_next.dir = s1.dir;
    if (s1.dir == DIR_ENCODE) begin
      s2_next.empty = (len == 2'd0);
      s2_next.c0    = {2'b00, m0[7:2]};
      s2_next.c1    = {2'b00, m0[1:0], m1[7:4]};
      s2_next.c2    = {1'b0, (len < 2'd2), m1[3:0], m2[7:6]};
      s2_next.c3    = {1'b0, (len < 2'd3), m2[5:0]};
    end else begin
      s2_next.empty = 1'b0;
      s2_next.c0    = dec_value(s1.b0);
      s2_next.c1    = dec_value(s1.b1);
      s2_next.c2    = dec_value(s1.b2);
      s2_next.c3    = dec_value(s1.b3);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (ready2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2) begin
      s2 <= s2_next;
    end
  end

  // indices to characters, or values packed into bytes
  always_comb begin
    res_next = '0;
    if (s2.dir == DIR_ENCODE) begin
      if (!s2.empty) begin
        res_next.b0    = enc_char(s2.c0[6:0]);
        res_next.b1    = enc_char(s2.c1[6:0]);
        res_next.b2    = enc_char(s2.c2[6:0]);
        res_next.b3    = enc_char(s2.c3[6:0]);
        res_next.count = COUNT_ENCODED;
      end else begin
        res_next.count = COUNT_NONE;
      end
    end else begin
      res_next.b0 = {s2.c0[5:0], 2'b00} | {4'b0000, s2.c1[7:4]};
      res_next.b1 = {s2.c1[3:0], 4'b0000} | {2'b00, s2.c2[7:2]};
      res_next.b2 = {s2.c2[1:0], 6'b000000} | s2.c3;
      if (s2.c2 >= PAD_VALUE) begin
        res_next.count = 3'(COUNT_FULL - 3'd2);
      end else if (s2.c3 >= PAD_VALUE) begin
        res_next.count = 3'(COUNT_FULL - 3'd1);
      end else begin
        res_next.count = COUNT_FULL;
      end
      res_next.error = (s2.c0 == BAD_VALUE) || (s2.c1 == BAD_VALUE) ||
                       (s2.c2 == BAD_VALUE) || (s2.c3 == BAD_VALUE);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ready3) begin
      res_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3) begin
      res <= res_next;
    end
  end

  assign out_valid = res_valid;
  assign out_b0    = res.b0;
  assign out_b1    = res.b1;
  assign out_b2    = res.b2;
  assign out_b3    = res.b3;
  assign out_count = res.count;
  assign out_error = res.error;

  // checks
  `B64VC_ASSERT_NEXT(a_s1_held, s1_valid && !ready2, s1_valid, "input stage item dropped")
  `B64VC_ASSERT_NOW(a_err_decode, out_valid && out_error, out_b3 == 8'd0, "error on encode result")
  `B64VC_ASSERT_NOW(a_empty_zero, out_valid && out_count == COUNT_NONE, out_b0 == 8'd0 && !out_error, "empty group not zero")

endmodule
